// File: design/arq_pkg.sv
// Shared types, constants and helper functions for the retransmit table.
package arq_pkg;

    localparam int TABLE_SLOTS_DEF = 8;
    localparam int MAX_PLAYERS_DEF = 8;

    localparam int TIME_W  = 32;
    localparam int SPAN_W  = 21;
    localparam int PING_W  = 17;
    localparam int SEQ_W   = 16;
    localparam int CFG_W   = 21;
    localparam int PCNT_W  = 4;
    localparam int CNT64_W = 7;

    localparam logic [TIME_W-1:0]  TIME_DIV    = 32'd18;
    localparam logic [TIME_W-1:0]  DELTA_CAP   = 32'h0002_0000;
    localparam logic [SPAN_W-1:0]  SPAN_CAP    = 21'd1966080;
    localparam logic [CNT64_W-1:0] RESULT_CAP  = 7'd64;

    localparam logic [CFG_W-1:0]  MAX_AGE_RST   = 21'd1310720;
    localparam logic [CFG_W-1:0]  RETRY_MIN_RST = 21'd131072;
    localparam logic [CFG_W-1:0]  RETRY_MAX_RST = 21'd327680;
    localparam logic [PCNT_W-1:0] PCOUNT_RST    = 4'd0;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_ACK  = 2'd2,
        OP_PING = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_RESEND  = 2'd0,
        KIND_RETIRED = 2'd1,
        KIND_NONE    = 2'd2,
        KIND_FULL    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_MAX_AGE      = 2'd0,
        CFG_RETRY_MIN    = 2'd1,
        CFG_RETRY_MAX    = 2'd2,
        CFG_PLAYER_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_kind             kind;
        logic [2:0]        slot;
        logic [2:0]        player;
        logic [SEQ_W-1:0]  seq;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    flush;
        t_result res;
    } t_oq_ctl;

    typedef struct packed {
        logic push_ok;
        logic flush_ok;
    } t_oq_sts;

    // Elapsed time from a stored stamp, zero if negative, saturated at 30 s.
    function automatic logic [SPAN_W-1:0] span(input logic [TIME_W-1:0] now,
                                               input logic [TIME_W-1:0] then_t);
        logic [TIME_W-1:0] d;
        d = now - then_t;
        if (d[TIME_W-1]) begin
            return '0;
        end else if (d > TIME_W'(SPAN_CAP)) begin
            return SPAN_CAP;
        end
        return d[SPAN_W-1:0];
    endfunction

    // Retry interval: four times the ping, raised to the minimum, then lowered to the maximum.
    function automatic logic [SPAN_W-1:0] retry_iv(input logic [PING_W-1:0] ping,
                                                   input logic [CFG_W-1:0]  lo,
                                                   input logic [CFG_W-1:0]  hi);
        logic [SPAN_W-1:0] iv;
        iv = SPAN_W'({ping, 2'b00});
        if (iv < lo) begin
            iv = lo;
        end
        if (iv > hi) begin
            iv = hi;
        end
        return iv;
    endfunction

endpackage

// File: design/arq_div18.sv
// Division of the raw timer value by the fixed time divisor through reciprocal multiplication.
module arq_div18
    import arq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    output logic              o_done,
    output logic [TIME_W-1:0] o_quotient
);

    // The quotient is floor(x * RECIP / 2^RECIP_SH). RECIP is the rounded-up reciprocal, and its
    // error times any 32-bit dividend stays below 2^RECIP_SH, so the result is exact.
    localparam int PROD_W   = 2 * TIME_W;
    localparam int RECIP_SH = 36;
    localparam logic [TIME_W-1:0] RECIP =
        TIME_W'(((PROD_W'(1) << RECIP_SH) + PROD_W'(TIME_DIV) - PROD_W'(1)) / PROD_W'(TIME_DIV));

    logic              r_stage;
    logic              r_done;
    logic [TIME_W-1:0] r_x;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    // The dividend is registered on start, then the product of it and the reciprocal.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_stage) begin
            r_prod <= PROD_W'(r_x) * PROD_W'(RECIP);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = TIME_W'(r_prod[PROD_W-1:RECIP_SH]);

endmodule

// File: design/arq_outq.sv
// Result holding stage and output register; marks the final result of each transaction.
module arq_outq
    import arq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_oq_ctl          i_ctl,
    output t_oq_sts          o_sts,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_slot,
    output logic [2:0]       o_player_out,
    output logic [SEQ_W-1:0] o_seq_out,
    output logic             o_last
);

    logic    r_valid;
    logic    r_pv;
    t_result r_pend;
    t_result r_out;
    logic    r_last;
    logic    out_free;
    t_result empty_res;

    assign out_free       = !r_valid || !i_stall;
    assign o_sts.push_ok  = !r_pv || out_free;
    assign o_sts.flush_ok = out_free;
    assign empty_res      = '{kind: KIND_NONE, slot: '0, player: '0, seq: '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            if (out_free) begin
                r_valid <= 1'b0;
            end
            if (i_ctl.push) begin
                if (r_pv) begin
                    r_valid <= 1'b1;
                end
                r_pv <= 1'b1;
            end else if (i_ctl.flush) begin
                r_valid <= 1'b1;
                r_pv    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_pend <= i_ctl.res;
            if (r_pv) begin
                r_out  <= r_pend;
                r_last <= 1'b0;
            end
        end else if (i_ctl.flush) begin
            r_out  <= r_pv ? r_pend : empty_res;
            r_last <= 1'b1;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_out.kind;
    assign o_slot       = r_out.slot;
    assign o_player_out = r_out.player;
    assign o_seq_out    = r_out.seq;
    assign o_last       = r_last;

endmodule

// File: design/ack_retransmit_table.sv
// Top level of the reliable-broadcast retransmit table with its sequencer and memories.
//
// The block keeps up to TABLE_SLOTS outstanding messages and, for each of up to MAX_PLAYERS
// players, the time of the last send. One transaction is handled at a time. A tick is accepted,
// divides the raw timer by 18 through a reciprocal multiply and advances game time, then walks
// the table: each entry passes an entry memory read and an evaluation, each unacked player of a
// kept entry a send-time memory read and a compare, an acked player only a check of its ack bit,
// and a closing state flags the last result. An add stamps every player's send time, an ack reads
// and evaluates each entry searched, and a ping update is accepted and then closed. Results leave
// through a one-deep holding stage and an output register, so the last result can be flagged and
// the next transaction is taken while a result still waits; a stalled output holds the walk at
// the next result. Retired entries are removed by rotating a small slot map rather than moving
// memory contents, so physical rows are reused.
module ack_retransmit_table
    import arq_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int MAX_PLAYERS = MAX_PLAYERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [TIME_W-1:0] i_timer_value,
    input  logic [SEQ_W-1:0]  i_seq_number,
    input  logic [2:0]        i_player_index,
    input  logic [PING_W-1:0] i_ping_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic [2:0]        o_slot,
    output logic [2:0]        o_player_out,
    output logic [SEQ_W-1:0]  o_seq_out,
    output logic              o_last
);

    localparam int SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PW    = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
    localparam int CW    = $clog2(TABLE_SLOTS + 1);
    localparam int NPW   = $clog2(MAX_PLAYERS + 1);
    localparam int TOTAL = TABLE_SLOTS * MAX_PLAYERS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int EW    = SEQ_W + TIME_W + MAX_PLAYERS;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DIV      = 11'b000_0000_0010,
        S_TIME     = 11'b000_0000_0100,
        S_ENT_RD   = 11'b000_0000_1000,
        S_ENT_EV   = 11'b000_0001_0000,
        S_PL_RD    = 11'b000_0010_0000,
        S_PL_EV    = 11'b000_0100_0000,
        S_ADD_FILL = 11'b000_1000_0000,
        S_ACK_RD   = 11'b001_0000_0000,
        S_ACK_EV   = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    // Configuration registers.
    logic [CFG_W-1:0]  r_max_age;
    logic [CFG_W-1:0]  r_retry_min;
    logic [CFG_W-1:0]  r_retry_max;
    logic [PCNT_W-1:0] r_player_count;

    // Control and timing state.
    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_gt, n_gt;
    logic [TIME_W-1:0]  r_last_scaled, n_last_scaled;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_map [TABLE_SLOTS];
    logic [SW-1:0]      n_map [TABLE_SLOTS];
    logic [PING_W-1:0]  r_ping [MAX_PLAYERS];
    logic [CW-1:0]      r_i, n_i;
    logic [NPW-1:0]     r_p, n_p;
    logic [SW-1:0]      r_phys, n_phys;
    logic [AW-1:0]      r_base, n_base;
    logic [SPAN_W-1:0]  r_iv, n_iv;
    logic [CNT64_W-1:0] r_ecnt, n_ecnt;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [2:0]         r_pl, n_pl;

    // Entry memory holds sequence number, birth time and ack bits per physical row;
    // the send memory holds one last-send time per row and player.
    logic [EW-1:0]     m_ent [TABLE_SLOTS];
    logic [EW-1:0]     r_ent_rd;
    logic [TIME_W-1:0] m_send [TOTAL];
    logic [TIME_W-1:0] r_send_rd;

    logic              ent_we, ent_re;
    logic [SW-1:0]     ent_waddr, ent_raddr;
    logic [EW-1:0]     ent_wdata;
    logic              send_we, send_re;
    logic [AW-1:0]     send_addr;
    logic              ping_we;

    logic              div_start, div_done;
    logic [TIME_W-1:0] div_quot;

    t_oq_ctl oq_ctl;
    t_oq_sts oq_sts;

    logic [SEQ_W-1:0]       ent_seq;
    logic [TIME_W-1:0]      ent_birth;
    logic [MAX_PLAYERS-1:0] ent_acks;
    logic [MAX_PLAYERS-1:0] ack_mask;
    logic [NPW-1:0]         np;
    logic [SW-1:0]          map_i, map_cnt;
    logic [NPW-1:0]         p_next;
    logic [CW-1:0]          i_next;
    logic                   last_p, last_i;
    logic                   can_emit, cap_hit;
    logic                   retire;
    logic [TIME_W-1:0]      delta;
    logic [AW-1:0]          cur_addr;
    logic                   pl_ok_in;

    assign ent_seq   = r_ent_rd[EW-1 -: SEQ_W];
    assign ent_birth = r_ent_rd[MAX_PLAYERS +: TIME_W];
    assign ent_acks  = r_ent_rd[MAX_PLAYERS-1:0];

    // Players scanned per entry; a count above the table width is used as the table width.
    assign np = (32'(r_player_count) > MAX_PLAYERS) ? NPW'(MAX_PLAYERS) : NPW'(r_player_count);

    always_comb begin
        for (int k = 0; k < MAX_PLAYERS; k++) begin
            ack_mask[k] = (k < int'(np));
        end
    end

    assign map_i    = r_map[r_i[SW-1:0]];
    assign map_cnt  = r_map[r_count[SW-1:0]];
    assign p_next   = r_p + NPW'(1);
    assign i_next   = r_i + CW'(1);
    assign last_p   = (p_next == np);
    assign last_i   = (i_next == r_count);
    assign cap_hit  = (r_ecnt == RESULT_CAP);
    assign can_emit = cap_hit || oq_sts.push_ok;
    assign cur_addr = r_base + AW'(r_p);
    assign pl_ok_in = (32'(i_player_index) < MAX_PLAYERS);

    // An entry leaves when it is too old or every scanned player has acked it.
    assign retire = (span(r_gt, ent_birth) >= r_max_age) || ((ent_acks & ack_mask) == ack_mask);

    always_comb begin
        logic [TIME_W-1:0] d;
        d = div_quot - r_last_scaled;
        if (d[TIME_W-1]) begin
            delta = '0;
        end else if (d > DELTA_CAP) begin
            delta = DELTA_CAP;
        end else begin
            delta = d;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_gt          = r_gt;
        n_last_scaled = r_last_scaled;
        n_count       = r_count;
        n_map         = r_map;
        n_i           = r_i;
        n_p           = r_p;
        n_phys        = r_phys;
        n_base        = r_base;
        n_iv          = r_iv;
        n_ecnt        = r_ecnt;
        n_seq         = r_seq;
        n_pl          = r_pl;
        ent_we        = 1'b0;
        ent_waddr     = r_phys;
        ent_wdata     = r_ent_rd;
        ent_re        = 1'b0;
        ent_raddr     = map_i;
        send_we       = 1'b0;
        send_re       = 1'b0;
        send_addr     = cur_addr;
        ping_we       = 1'b0;
        div_start     = 1'b0;
        oq_ctl        = '0;
        oq_ctl.res    = '{kind: KIND_NONE, slot: '0, player: '0, seq: i_seq_number};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_seq  = i_seq_number;
                    n_pl   = i_player_index;
                    n_ecnt = '0;
                    n_i    = '0;
                    n_p    = '0;
                    case (t_opcode'(i_opcode))
                        OP_TICK: begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        OP_ADD: begin
                            oq_ctl.push = 1'b1;
                            if (32'(r_count) < TABLE_SLOTS) begin
                                ent_we         = 1'b1;
                                ent_waddr      = map_cnt;
                                ent_wdata      = {i_seq_number, r_gt, {MAX_PLAYERS{1'b0}}};
                                n_base         = AW'(int'(map_cnt) * MAX_PLAYERS);
                                oq_ctl.res.slot = 3'(r_count);
                                n_state        = S_ADD_FILL;
                            end else begin
                                oq_ctl.res.kind = KIND_FULL;
                                n_state         = S_DONE;
                            end
                        end
                        OP_ACK: begin
                            if (pl_ok_in && (r_count != '0)) begin
                                n_state = S_ACK_RD;
                            end else begin
                                oq_ctl.push = 1'b1;
                                n_state     = S_DONE;
                            end
                        end
                        OP_PING: begin
                            ping_we     = pl_ok_in;
                            oq_ctl.push = 1'b1;
                            n_state     = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD_FILL: begin
                send_we = 1'b1;
                if (r_p == NPW'(MAX_PLAYERS - 1)) begin
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_p = p_next;
                end
            end

            S_ACK_RD: begin
                ent_re  = 1'b1;
                n_phys  = map_i;
                n_state = S_ACK_EV;
            end

            S_ACK_EV: begin
                oq_ctl.res.seq = r_seq;
                if (ent_seq == r_seq) begin
                    ent_we          = 1'b1;
                    ent_wdata       = {ent_seq, ent_birth,
                                       ent_acks | (MAX_PLAYERS'(1) << r_pl)};
                    oq_ctl.push     = 1'b1;
                    oq_ctl.res.slot = 3'(r_i);
                    n_state         = S_DONE;
                end else if (last_i) begin
                    oq_ctl.push = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_i     = i_next;
                    n_state = S_ACK_RD;
                end
            end

            S_DIV: begin
                if (div_done) begin
                    n_state = S_TIME;
                end
            end

            S_TIME: begin
                n_gt          = r_gt + delta;
                n_last_scaled = div_quot;
                n_i           = '0;
                n_state       = (r_count == '0) ? S_DONE : S_ENT_RD;
            end

            S_ENT_RD: begin
                ent_re  = 1'b1;
                n_phys  = map_i;
                n_base  = AW'(int'(map_i) * MAX_PLAYERS);
                n_state = S_ENT_EV;
            end

            S_ENT_EV: begin
                oq_ctl.res = '{kind: KIND_RETIRED, slot: 3'(r_i), player: '0, seq: ent_seq};
                if (retire) begin
                    if (can_emit) begin
                        oq_ctl.push = !cap_hit;
                        n_ecnt      = cap_hit ? r_ecnt : r_ecnt + CNT64_W'(1);
                        // Close the gap: later slots move down, the freed row goes last.
                        for (int k = 0; k < TABLE_SLOTS - 1; k++) begin
                            if (k >= int'(r_i)) begin
                                n_map[k] = r_map[k + 1];
                            end
                        end
                        n_map[TABLE_SLOTS - 1] = map_i;
                        n_count = r_count - CW'(1);
                        n_state = last_i ? S_DONE : S_ENT_RD;
                    end
                end else begin
                    n_p     = '0;
                    n_state = S_PL_RD;
                end
            end

            S_PL_RD: begin
                if (ent_acks[r_p[PW-1:0]]) begin
                    if (last_p) begin
                        n_i     = i_next;
                        n_state = last_i ? S_DONE : S_ENT_RD;
                    end else begin
                        n_p = p_next;
                    end
                end else begin
                    send_re = 1'b1;
                    n_iv    = retry_iv(r_ping[r_p[PW-1:0]], r_retry_min, r_retry_max);
                    n_state = S_PL_EV;
                end
            end

            S_PL_EV: begin
                oq_ctl.res = '{kind: KIND_RESEND, slot: 3'(r_i), player: 3'(r_p), seq: ent_seq};
                if (!(r_iv < span(r_gt, r_send_rd)) || can_emit) begin
                    if (r_iv < span(r_gt, r_send_rd)) begin
                        oq_ctl.push = !cap_hit;
                        n_ecnt      = cap_hit ? r_ecnt : r_ecnt + CNT64_W'(1);
                        send_we     = 1'b1;
                    end
                    if (last_p) begin
                        n_i     = i_next;
                        n_state = last_i ? S_DONE : S_ENT_RD;
                    end else begin
                        n_p     = p_next;
                        n_state = S_PL_RD;
                    end
                end
            end

            S_DONE: begin
                if (oq_sts.flush_ok) begin
                    oq_ctl.flush = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_gt          <= '0;
            r_last_scaled <= '0;
            r_count       <= '0;
            r_ecnt        <= '0;
            r_i           <= '0;
            r_p           <= '0;
            for (int k = 0; k < TABLE_SLOTS; k++) begin
                r_map[k] <= SW'(k);
            end
            for (int k = 0; k < MAX_PLAYERS; k++) begin
                r_ping[k] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_gt          <= n_gt;
            r_last_scaled <= n_last_scaled;
            r_count       <= n_count;
            r_ecnt        <= n_ecnt;
            r_i           <= n_i;
            r_p           <= n_p;
            r_map         <= n_map;
            if (ping_we) begin
                for (int k = 0; k < MAX_PLAYERS; k++) begin
                    if (k == int'(i_player_index)) begin
                        r_ping[k] <= i_ping_value;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phys <= n_phys;
        r_base <= n_base;
        r_iv   <= n_iv;
        r_seq  <= n_seq;
        r_pl   <= n_pl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age      <= MAX_AGE_RST;
            r_retry_min    <= RETRY_MIN_RST;
            r_retry_max    <= RETRY_MAX_RST;
            r_player_count <= PCOUNT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_AGE:      r_max_age      <= i_cfg_wdata;
                CFG_RETRY_MIN:    r_retry_min    <= i_cfg_wdata;
                CFG_RETRY_MAX:    r_retry_max    <= i_cfg_wdata;
                CFG_PLAYER_COUNT: r_player_count <= i_cfg_wdata[PCNT_W-1:0];
                default:          r_player_count <= r_player_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            m_ent[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_rd <= m_ent[ent_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (send_we) begin
            m_send[send_addr] <= r_gt;
        end
        if (send_re) begin
            r_send_rd <= m_send[send_addr];
        end
    end

    arq_div18 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_timer_value),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    arq_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (oq_ctl),
        .o_sts        (oq_sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_slot       (o_slot),
        .o_player_out (o_player_out),
        .o_seq_out    (o_seq_out),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= TABLE_SLOTS)
        else $error("entry count exceeds table size");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= RESULT_CAP)
        else $error("result count exceeds cap");

    a_tick_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_opcode == OP_TICK)) |=> (r_state == S_DIV))
        else $error("tick did not start the divider");

    a_push_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_ctl.push |-> oq_sts.push_ok)
        else $error("result pushed while holding stage blocked");
`endif

endmodule
